@@ rtl/cln_pkg.sv @@
package cln_pkg;

	localparam int MAX_BYTES = 7;
	localparam int NUM_LOW_DIGITS = 4;

	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_CMD    = 3'd1;
	localparam logic [2:0] OP_DATA   = 3'd2;
	localparam logic [2:0] OP_CURSOR = 3'd3;
	localparam logic [2:0] OP_NUMBER = 3'd4;

	localparam logic [7:0] CMD_HOME   = 8'h80;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_ERROR = 8'h45;
	localparam logic [3:0] MAX_DIGITS = 4'd5;

	// reciprocal of ten, exact for every 16-bit dividend after a shift by 19
	localparam logic [15:0] RECIP_TEN = 16'd52429;
	localparam int RECIP_SHIFT = 19;

	// the raw wake-up nibbles 3,3,3,2 pack into the bytes 0x33 and 0x32
	localparam logic [MAX_BYTES-1:0][7:0] INIT_BYTES = {
		8'h80, 8'h0E, 8'h06, 8'h01, 8'h28, 8'h32, 8'h33
	};

	typedef struct packed {
		logic [2:0]       opcode;
		logic [7:0]       byte_value;
		logic [2:0]       row;
		logic [5:0]       column;
		logic [3:0]       digit_count;
		logic [15:0]      rest;
		logic [NUM_LOW_DIGITS-1:0][3:0] digits;
	} cln_item_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [MAX_BYTES-1:0]      rs;
		logic [2:0]                count;
	} cln_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} cln_qstat_t;

	function automatic logic [7:0] row_base(input logic [2:0] row);
		logic [7:0] b;
		unique case (row)
			3'd1: b = 8'h80;
			3'd2: b = 8'hC0;
			3'd3: b = 8'h94;
			3'd4: b = 8'hD4;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic row_ok(input logic [2:0] row);
		return (row >= 3'd1) && (row <= 3'd4);
	endfunction

	// one decimal digit peeled off the bottom per call
	function automatic cln_item_t digit_step(input cln_item_t it);
		cln_item_t  o;
		logic [31:0] prod;
		logic [15:0] quot;
		logic [15:0] diff;
		o    = it;
		prod = 32'(it.rest) * 32'(RECIP_TEN);
		quot = 16'(prod >> RECIP_SHIFT);
		diff = it.rest - ((quot << 3) + (quot << 1));
		o.rest   = quot;
		o.digits = {diff[3:0], it.digits[NUM_LOW_DIGITS-1:1]};
		return o;
	endfunction

	function automatic cln_entry_t build_entry(input cln_item_t it);
		cln_entry_t e;
		logic [7:0] cur;
		logic       pos;
		logic [2:0] k;
		logic [7:0] ch;
		logic [2:0] slot;
		e   = '0;
		cur = 8'(row_base(it.row) + {2'b00, it.column} - 8'd1);
		pos = 1'b0;
		k   = '0;
		ch  = '0;
		slot = '0;
		unique case (it.opcode)
			OP_INIT: begin
				e.bytes = INIT_BYTES;
				e.count = 3'(MAX_BYTES);
			end
			OP_CMD: begin
				e.bytes[0] = it.byte_value;
				e.count    = 3'd1;
			end
			OP_DATA: begin
				e.bytes[0] = it.byte_value;
				e.rs[0]    = 1'b1;
				e.count    = 3'd1;
			end
			OP_CURSOR: begin
				if (row_ok(it.row)) begin
					e.bytes[0] = cur;
					e.count    = 3'd1;
				end
			end
			OP_NUMBER: begin
				if (it.row == 3'd0 || it.column == 6'd0) begin
					e.bytes[0] = CMD_HOME;
					pos = 1'b1;
				end else if (row_ok(it.row)) begin
					e.bytes[0] = cur;
					pos = 1'b1;
				end
				if (it.digit_count > MAX_DIGITS) begin
					e.bytes[pos] = CHAR_ERROR;
					e.rs[pos]    = 1'b1;
					e.count      = 3'(pos) + 3'd1;
				end else begin
					for (int j = 0; j < 5; j++) begin
						if (4'(j) < it.digit_count) begin
							k  = 3'(it.digit_count - 4'd1 - 4'(j));
							ch = (k == 3'd4) ? 8'(it.rest) + CHAR_ZERO
							                 : {4'd0, it.digits[k[1:0]]} + CHAR_ZERO;
							slot = 3'(j) + 3'(pos);
							e.bytes[slot] = ch;
							e.rs[slot]    = 1'b1;
						end
					end
					e.count = 3'(pos) + it.digit_count[2:0];
				end
			end
			default: e.count = 3'd0;
		endcase
		return e;
	endfunction

endpackage

@@ rtl/cln_front.sv @@
module cln_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          opcode,
	input  logic [7:0]          byte_value,
	input  logic [2:0]          row,
	input  logic [5:0]          column,
	input  logic [15:0]         number,
	input  logic [3:0]          digit_count,
	input  logic                q_full,
	output logic                push,
	output cln_pkg::cln_entry_t entry
);
	import cln_pkg::*;

	cln_item_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic      en1, en2, en3, en4, en5, en_out;
	logic      empty_s5;

	assign entry    = build_entry(item_s5);
	assign empty_s5 = (entry.count == 3'd0);

	// requests that send nothing are dropped here
	assign en_out = !v_s5 || empty_s5 || !q_full;
	assign push   = v_s5 && !empty_s5 && !q_full;

	assign en5 = !v_s5 || en_out;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			item_s1.opcode      <= opcode;
			item_s1.byte_value  <= byte_value;
			item_s1.row         <= row;
			item_s1.column      <= column;
			item_s1.digit_count <= digit_count;
			item_s1.rest        <= number;
			item_s1.digits      <= '0;
		end
		if (en2) item_s2 <= digit_step(item_s1);
		if (en3) item_s3 <= digit_step(item_s2);
		if (en4) item_s4 <= digit_step(item_s3);
		if (en5) item_s5 <= digit_step(item_s4);
	end

endmodule

@@ rtl/cln_queue.sv @@
module cln_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cln_pkg::cln_entry_t wr_entry,
	input  logic                pop,
	output cln_pkg::cln_entry_t head,
	output cln_pkg::cln_qstat_t stat
);
	import cln_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cln_entry_t      slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (fill_q == CW'(0));
	assign stat.full  = (fill_q == CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				fill_q <= fill_q + CW'(1);
			else if (pop && !push)
				fill_q <= fill_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_entry;
	end

endmodule

@@ rtl/cln_back.sv @@
module cln_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cln_pkg::cln_entry_t head,
	input  cln_pkg::cln_qstat_t stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                reg_select,
	output logic [3:0]          nibble,
	output logic                last
);
	import cln_pkg::*;

	logic [3:0] idx_q;
	logic       adv;
	logic       take;
	logic       final_nib;
	logic [7:0] cur_byte;
	logic [2:0] bsel;

	assign adv       = !out_valid || !out_stall;
	assign take      = adv && !stat.empty;
	assign bsel      = idx_q[3:1];
	assign cur_byte  = head.bytes[bsel];
	assign final_nib = (idx_q == ({head.count, 1'b0} - 4'd1));
	assign pop       = take && final_nib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else if (adv) begin
			out_valid <= !stat.empty;
			if (take)
				idx_q <= final_nib ? 4'd0 : idx_q + 4'd1;
		end
	end

	// high nibble on even index
	always_ff @(posedge clk) begin
		if (take) begin
			reg_select <= head.rs[bsel];
			nibble     <= idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
			last       <= final_nib;
		end
	end

endmodule

@@ rtl/char_lcd_nibble_writer.sv @@
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------------
// request   | in_valid / in_stall    | opcode, byte_value, row, column, number,
//           |                        | digit_count
// transfer  | out_valid / out_stall  | reg_select, nibble, last
//
// a request sends two nibbles per byte, so up to 14 nibbles (init),
// all through the single nibble output register
// the front has one capture stage and four divide-by-ten stages
// requests are taken every cycle while the transaction queue has room
// reset clears only valid bits, pointers, the fill count and the nibble index
// out_stall holds the output register; in_stall rises once the front pipe backs up
module char_lcd_nibble_writer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  byte_value,
	input  logic [2:0]  row,
	input  logic [5:0]  column,
	input  logic [15:0] number,
	input  logic [3:0]  digit_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_select,
	output logic [3:0]  nibble,
	output logic        last
);
	import cln_pkg::*;

	cln_entry_t wr_entry;
	cln_entry_t head;
	cln_qstat_t stat;
	logic       push;
	logic       pop;

	// front: captures the request, peels decimal digits, packs a byte list
	cln_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.byte_value (byte_value),
		.row        (row),
		.column     (column),
		.number     (number),
		.digit_count(digit_count),
		.q_full     (stat.full),
		.push       (push),
		.entry      (wr_entry)
	);

	// short queue of byte lists between the two halves
	cln_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	// back: walks the head byte list one nibble per cycle unless out_stall holds it, high nibble first
	cln_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.reg_select(reg_select),
		.nibble    (nibble),
		.last      (last)
	);

	// the back never retires a list the queue does not hold
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

	// the front never overruns the queue
	a_push_nonfull: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

	// empty requests are dropped before the queue
	a_push_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wr_entry.count != 3'd0))
		else $error("empty byte list queued");

	// retiring a list from a queue with room cannot leave it full next cycle
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !stat.full) |=> !stat.full)
		else $error("queue filled while retiring a list");

endmodule
